// ===== src/caf_pkg.sv =====
// ----------------------------------------------------------------------------
// caf_pkg
// Shared constants, types and the arctangent table of the attitude filter.
// ----------------------------------------------------------------------------
package caf_pkg;

    localparam int unsigned CfgAddrW = 4;

    localparam logic [CfgAddrW-1:0] RegBlendWeight  = 4'h0;
    localparam logic [CfgAddrW-1:0] RegDecimation   = 4'h4;
    localparam logic [CfgAddrW-1:0] RegInvalidLimit = 4'h8;

    localparam logic [15:0] BlendWeightRst  = 16'd64225;
    localparam logic [7:0]  DecimationRst   = 8'd1;
    localparam logic [7:0]  InvalidLimitRst = 8'd10;

    localparam logic [63:0] PiQ62 = 64'hC90FDAA22168C235;
    localparam logic signed [15:0] OutLim = 16'sd25736;

    typedef struct packed {
        logic        sample_valid;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [15:0] time_step;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic        imu_ok;
        logic        attitude_updated;
    } t_result;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        begin
            case (idx)
                5'd0:  v = 30'd843314857;
                5'd1:  v = 30'd497837829;
                5'd2:  v = 30'd263043837;
                5'd3:  v = 30'd133525159;
                5'd4:  v = 30'd67021687;
                5'd5:  v = 30'd33543516;
                5'd6:  v = 30'd16775851;
                5'd7:  v = 30'd8388437;
                5'd8:  v = 30'd4194283;
                5'd9:  v = 30'd2097149;
                default: v = (idx < 5'd30) ? (30'd1 << (5'd30 - idx)) : 30'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== src/caf_if.sv =====
// ----------------------------------------------------------------------------
// caf_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface caf_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/complementary_attitude_filter.sv =====
// ----------------------------------------------------------------------------
// complementary_attitude_filter
// Complementary filter for roll, pitch and yaw from one IMU sample per beat.
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  s_in      in   t_sample: valid flag, gyro xyz, accel xyz, time step
//  m_out     out  t_result: roll, pitch, yaw, imu_ok, attitude_updated
//  apb       in   blend_weight, decimation, invalid_limit
//
//  invalid or decimated-out samples go from S_CHECK straight to S_OUT, where the
//  result is registered, and then to S_HOLD
//  updates with nonzero accel first run roll and pitch through the shared CORDIC,
//  then each axis through the shared multiplier before S_OUT
//  reset is synchronous active low and clears the counters and angles
//  input is not taken while a beat is in work or the result waits; S_HOLD is left
//  only with m_out.ready high, and s_in.ready rises in the following cycle
// ----------------------------------------------------------------------------
module complementary_attitude_filter
    import caf_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS    = 16,
    parameter int unsigned ANGLE_FRAC_BITS = 28
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    caf_if.sink                 s_in,
    caf_if.source               m_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam logic [63:0] PiRnd = (PiQ62 + (64'd1 << (61 - ANGLE_FRAC_BITS)))
                                    >> (62 - ANGLE_FRAC_BITS);
    localparam logic signed [47:0] Pi48 = $signed({16'd0, PiRnd[31:0]});
    localparam int unsigned IncSh = 28 - ANGLE_FRAC_BITS;
    localparam int unsigned OutSh = ANGLE_FRAC_BITS - 13;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CHECK = 11'b00000000010,
        S_ROLLA = 11'b00000000100,
        S_ROLLW = 11'b00000001000,
        S_PITW  = 11'b00000010000,
        S_INC1  = 11'b00000100000,
        S_INC2  = 11'b00001000000,
        S_BL1   = 11'b00010000000,
        S_BL2   = 11'b00100000000,
        S_OUT   = 11'b01000000000,
        S_HOLD  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    t_sample r_smp;
    logic [15:0] r_alpha;
    logic [7:0]  r_decim, r_ilim, r_icnt, r_dcnt;
    logic        r_ok, r_upd;
    logic signed [31:0] r_ang [3];
    logic signed [31:0] r_acc [2];
    logic signed [31:0] r_inc;
    logic signed [47:0] r_prod;
    logic [1:0]  r_axis;
    t_result     r_res;

    logic [7:0] dec_eff;
    assign dec_eff = (r_decim == 8'd0) ? 8'd1 : r_decim;

    // cordic
    logic cd_start, cd_done;
    logic signed [16:0] cd_y, cd_x;
    logic signed [31:0] cd_angle;
    caf_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cd_start),
        .i_y(cd_y), .i_x(cd_x), .o_done(cd_done), .o_angle(cd_angle)
    );

    // shared multiplier
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [15:0] rate;
    always_comb begin
        case (r_axis)
            2'd0:    rate = r_smp.gyro_x;
            2'd1:    rate = r_smp.gyro_y;
            default: rate = r_smp.gyro_z;
        endcase
    end

    logic signed [47:0] inc_p, inc_r, inc_c, bl_s, bl_w;
    logic signed [32:0] ang_sum;
    always_comb begin
        inc_p = 48'(mul_p);
        if (r_axis == 2'd1) inc_p = -inc_p;
        inc_r = (IncSh == 0) ? inc_p : ((inc_p + (48'sd1 <<< (IncSh - 1))) >>> IncSh);
        inc_c = (inc_r > Pi48) ? Pi48 : (inc_r < -Pi48) ? -Pi48 : inc_r;
        ang_sum = 33'(r_ang[r_axis]) + 33'(r_inc);
    end

    always_comb begin
        mul_a = '0; mul_b = '0;
        case (r_state)
            S_INC1:  begin mul_a = 33'(rate); mul_b = $signed({2'b00, r_smp.time_step}); end
            S_INC2:  begin mul_a = 33'(r_prod); mul_b = $signed({10'd0, dec_eff}); end
            S_BL1:   begin mul_a = ang_sum; mul_b = $signed({2'b00, r_alpha}); end
            S_BL2:   begin
                mul_a = 33'(r_acc[r_axis[0]]);
                mul_b = $signed(18'h10000 - {2'b00, r_alpha});
            end
            default: ;
        endcase
    end

    always_comb begin
        bl_s = (r_prod + 48'(mul_p) + 48'sd32768) >>> 16;
        if (r_axis == 2'd2) bl_s = 48'(ang_sum);
        bl_w = (bl_s > Pi48) ? bl_s - 2 * Pi48 : (bl_s < -Pi48) ? bl_s + 2 * Pi48 : bl_s;
    end

    logic accel_nz;
    assign accel_nz = (r_smp.accel_x != 0) || (r_smp.accel_y != 0) || (r_smp.accel_z != 0);

    always_comb begin
        cd_start = 1'b0;
        cd_y = -17'(r_smp.accel_y); cd_x = -17'(r_smp.accel_z);
        if (r_state == S_ROLLA) cd_start = 1'b1;
        if (r_state == S_ROLLW && cd_done) begin
            cd_start = 1'b1; cd_y = -17'(r_smp.accel_x);
        end
    end

    function automatic logic signed [15:0] out_ang(input logic signed [31:0] v);
        logic signed [31:0] r;
        begin
            r = (v + (32'sd1 <<< (OutSh - 1))) >>> OutSh;
            if (r > 32'(OutLim)) r = 32'(OutLim);
            if (r < -32'(OutLim)) r = -32'(OutLim);
            return r[15:0];
        end
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_in.valid) n_state = S_CHECK;
            S_CHECK: begin
                if (!r_smp.sample_valid || r_smp.time_step == 0 || r_dcnt + 8'd1 < dec_eff)
                    n_state = S_OUT;
                else n_state = accel_nz ? S_ROLLA : S_INC1;
            end
            S_ROLLA: n_state = S_ROLLW;
            S_ROLLW: if (cd_done) n_state = S_PITW;
            S_PITW:  if (cd_done) n_state = S_INC1;
            S_INC1:  n_state = S_INC2;
            S_INC2:  n_state = (r_axis == 2'd2) ? S_BL2 : S_BL1;
            S_BL1:   n_state = S_BL2;
            S_BL2:   n_state = (r_axis == 2'd2) ? S_OUT : S_INC1;
            S_OUT:   n_state = S_HOLD;
            S_HOLD:  if (m_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready) r_smp <= s_in.data;
        if (r_state == S_INC1) r_prod <= 48'(mul_p);
        if (r_state == S_INC2) begin
            r_inc  <= inc_c[31:0];
            r_prod <= '0;
        end
        if (r_state == S_BL1) r_prod <= 48'(mul_p);
        if (r_state == S_ROLLW && cd_done) r_acc[0] <= cd_angle;
        if (r_state == S_PITW && cd_done) r_acc[1] <= cd_angle;
        if (r_state == S_OUT) begin
            r_res.roll_angle  <= out_ang(r_ang[0]);
            r_res.pitch_angle <= out_ang(r_ang[1]);
            r_res.yaw_angle   <= out_ang(r_ang[2]);
            r_res.imu_ok      <= r_ok;
            r_res.attitude_updated <= r_upd;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_alpha <= BlendWeightRst; r_decim <= DecimationRst; r_ilim <= InvalidLimitRst;
            r_icnt <= '0; r_dcnt <= '0; r_ok <= 1'b1; r_upd <= 1'b0; r_axis <= '0;
            r_ang[0] <= '0; r_ang[1] <= '0; r_ang[2] <= '0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite) begin
                case (paddr)
                    RegBlendWeight:  r_alpha <= pwdata[15:0];
                    RegDecimation:   r_decim <= pwdata[7:0];
                    RegInvalidLimit: r_ilim  <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (r_state == S_CHECK) begin
                r_axis <= '0;
                r_upd  <= 1'b0;
                if (!r_smp.sample_valid || r_smp.time_step == 0) begin
                    if (r_icnt < r_ilim) begin
                        r_icnt <= r_icnt + 8'd1;
                        r_ok   <= (r_icnt + 8'd1) < r_ilim;
                    end else r_ok <= 1'b0;
                end else begin
                    r_icnt <= '0; r_ok <= 1'b1;
                    if (r_dcnt + 8'd1 < dec_eff) r_dcnt <= r_dcnt + 8'd1;
                    else begin
                        r_dcnt <= '0; r_upd <= 1'b1;
                        if (!accel_nz) begin
                            r_acc[0] <= r_ang[0]; r_acc[1] <= r_ang[1];
                        end
                    end
                end
            end
            if (r_state == S_BL2) begin
                r_ang[r_axis] <= bl_w[31:0];
                r_axis <= r_axis + 2'd1;
            end
        end
    end

    assign s_in.ready  = (r_state == S_IDLE);
    assign m_out.valid = (r_state == S_HOLD);
    assign m_out.data  = r_res;
    assign pready      = 1'b1;

    always_comb begin
        case (paddr)
            RegBlendWeight:  prdata = {16'd0, r_alpha};
            RegDecimation:   prdata = {24'd0, r_decim};
            RegInvalidLimit: prdata = {24'd0, r_ilim};
            default:         prdata = '0;
        endcase
    end
endmodule

// ===== src/caf_cordic.sv =====
// ----------------------------------------------------------------------------
// caf_cordic
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module caf_cordic
    import caf_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS    = 16,
    parameter int unsigned ANGLE_FRAC_BITS = 28
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_y,
    input  logic signed [16:0] i_x,
    output logic               o_done,
    output logic signed [31:0] o_angle
);
    localparam int unsigned StepW = 5;
    localparam int unsigned Sh    = 30 - ANGLE_FRAC_BITS;
    localparam logic [63:0] PiRnd = (PiQ62 + (64'd1 << (61 - ANGLE_FRAC_BITS)))
                                    >> (62 - ANGLE_FRAC_BITS);
    localparam logic signed [33:0] PiS = $signed({2'b00, PiRnd[31:0]});

    logic signed [49:0] r_x, r_y, n_x, n_y;
    logic signed [33:0] r_z, n_z;
    logic [StepW-1:0]   r_step, n_step;
    logic               r_busy, n_busy, r_done, n_done;
    logic signed [33:0] t_rot;
    logic [30:0]        t_raw;

    always_comb begin
        t_raw = {1'b0, atan_q30(r_step)};
        if (Sh == 0) t_rot = $signed({3'b000, t_raw});
        else t_rot = $signed({3'b000, (t_raw + (31'd1 << (Sh - 1))) >> Sh});
        n_x = r_x; n_y = r_y; n_z = r_z; n_step = r_step;
        n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_step = '0;
            n_z    = '0;
            if (i_x == 0 && i_y == 0) begin
                n_busy = 1'b0; n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                if (i_x < 0) begin
                    n_z = (i_y >= 0) ? PiS : -PiS;
                    n_x = 50'(-i_x) <<< 30;
                    n_y = 50'(-i_y) <<< 30;
                end else begin
                    n_x = 50'(i_x) <<< 30;
                    n_y = 50'(i_y) <<< 30;
                end
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                n_x = r_x + (r_y >>> r_step);
                n_y = r_y - (r_x >>> r_step);
                n_z = r_z + t_rot;
            end else begin
                n_x = r_x - (r_y >>> r_step);
                n_y = r_y + (r_x >>> r_step);
                n_z = r_z - t_rot;
            end
            n_step = r_step + 1'b1;
            if (32'(n_step) >= CORDIC_STEPS || 32'(n_step) >= 30) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_step <= n_step;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end

    assign o_done  = r_done;
    assign o_angle = (r_z > PiS) ? PiS[31:0] : (r_z < -PiS) ? 32'(-PiS) : r_z[31:0];
endmodule

// ===== tb/sv/complementary_attitude_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complementary_attitude_filter_test
// Self-checking bench for the attitude filter. Samples go in over the input
// channel with random gaps, and results are checked beat by beat against a
// bit-exact predictor of the counters, the CORDIC and the blend. The run
// steps through several register settings written over APB while idle.
// ----------------------------------------------------------------------------
module complementary_attitude_filter_test;
    import caf_pkg::*;

    localparam int unsigned CordicSteps = 16;
    localparam int unsigned CycleLimit  = 2000000;
    localparam int unsigned DrainCycles = 60;

    localparam longint AtanQ30 [CordicSteps] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CfgAddrW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    caf_if #(.T(t_sample)) in_ch ();
    caf_if #(.T(t_result)) out_ch ();

    complementary_attitude_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch),
        .m_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    longint unsigned weight_q;
    longint unsigned decim_q;
    longint unsigned limit_q;
    longint unsigned bad_count;
    bit              ok_q;
    longint unsigned decim_cnt;
    longint          roll_q;
    longint          pitch_q;
    longint          yaw_q;
    longint          pi_fix;

    t_result attitude_q[$];
    int      errors;
    int unsigned cycles;
    bit      no_idle;
    int      sink_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint clamp_l(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint wrap_pi(longint v);
        if (v > pi_fix) return v - 2 * pi_fix;
        if (v < -pi_fix) return v + 2 * pi_fix;
        return v;
    endfunction

    function automatic longint atan2_fix(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        longint t;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? pi_fix : -pi_fix;
            x = -x;
            y = -y;
        end
        x = x * (64'sd1 <<< 30);
        y = y * (64'sd1 <<< 30);
        for (int i = 0; i < CordicSteps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            t  = (AtanQ30[i] + 2) >>> 2;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + t;
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - t;
            end
        end
        return clamp_l(z, pi_fix);
    endfunction

    function automatic longint blend_angle(longint ang, longint inc, longint acc);
        longint a;
        a = longint'(weight_q);
        return wrap_pi((a * (ang + inc) + (65536 - a) * acc + 32768) >>> 16);
    endfunction

    function automatic logic [15:0] angle_out(longint v);
        return 16'(clamp_l((v + 16384) >>> 15, 25736));
    endfunction

    function automatic t_result predict_attitude(t_sample s);
        t_result r;
        longint dec;
        longint dt;
        longint ax;
        longint ay;
        longint az;
        longint roll_acc;
        longint pitch_acc;
        longint inc_x;
        longint inc_y;
        longint inc_z;
        r.attitude_updated = 1'b0;
        if (!s.sample_valid || s.time_step == 16'd0) begin
            if (bad_count < limit_q) bad_count++;
            ok_q = (bad_count < limit_q);
        end else begin
            dec = (decim_q == 0) ? 1 : longint'(decim_q);
            bad_count = 0;
            ok_q = 1'b1;
            decim_cnt++;
            if (longint'(decim_cnt) >= dec) begin
                decim_cnt = 0;
                r.attitude_updated = 1'b1;
                dt = longint'(s.time_step);
                ax = longint'(s.accel_x);
                ay = longint'(s.accel_y);
                az = longint'(s.accel_z);
                roll_acc  = roll_q;
                pitch_acc = pitch_q;
                if (ax != 0 || ay != 0 || az != 0) begin
                    roll_acc  = atan2_fix(-ay, -az);
                    pitch_acc = atan2_fix(-ax, -az);
                end
                inc_x = clamp_l(longint'(s.gyro_x) * dt * dec, pi_fix);
                inc_y = clamp_l(-longint'(s.gyro_y) * dt * dec, pi_fix);
                inc_z = clamp_l(longint'(s.gyro_z) * dt * dec, pi_fix);
                roll_q  = longint'(32'(blend_angle(roll_q, inc_x, roll_acc)));
                pitch_q = longint'(32'(blend_angle(pitch_q, inc_y, pitch_acc)));
                yaw_q   = longint'(32'(wrap_pi(yaw_q + inc_z)));
            end
        end
        r.roll_angle  = angle_out(roll_q);
        r.pitch_angle = angle_out(pitch_q);
        r.yaw_angle   = angle_out(yaw_q);
        r.imu_ok      = ok_q;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (attitude_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                exp_r = attitude_q.pop_front();
                if (out_ch.data.roll_angle !== exp_r.roll_angle) begin
                    $error("roll_angle exp %0d got %0d", exp_r.roll_angle,
                           out_ch.data.roll_angle);
                    errors++;
                end
                if (out_ch.data.pitch_angle !== exp_r.pitch_angle) begin
                    $error("pitch_angle exp %0d got %0d", exp_r.pitch_angle,
                           out_ch.data.pitch_angle);
                    errors++;
                end
                if (out_ch.data.yaw_angle !== exp_r.yaw_angle) begin
                    $error("yaw_angle exp %0d got %0d", exp_r.yaw_angle,
                           out_ch.data.yaw_angle);
                    errors++;
                end
                if (out_ch.data.imu_ok !== exp_r.imu_ok) begin
                    $error("imu_ok exp %0b got %0b", exp_r.imu_ok, out_ch.data.imu_ok);
                    errors++;
                end
                if (out_ch.data.attitude_updated !== exp_r.attitude_updated) begin
                    $error("attitude_updated exp %0b got %0b", exp_r.attitude_updated,
                           out_ch.data.attitude_updated);
                    errors++;
                end
            end
        end
    end

    // result ready with random stalls and long hold-offs
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            out_ch.ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (no_idle || $urandom_range(0, 5) != 0) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= 1'b0;
            sink_hold <= $urandom_range(0, 14);
        end
    end

    task automatic send_sample(t_sample s);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= s;
        do @(posedge i_clk); while (!in_ch.ready);
        attitude_q.push_back(predict_attitude(s));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (attitude_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [CfgAddrW-1:0] addr, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == RegBlendWeight) weight_q = value[15:0];
        else if (addr == RegDecimation) decim_q = value[7:0];
        else if (addr == RegInvalidLimit) limit_q = value[7:0];
    endtask

    task automatic set_filter(logic [31:0] weight, logic [31:0] decim, logic [31:0] lim);
        apb_write(RegBlendWeight, weight);
        apb_write(RegDecimation, decim);
        apb_write(RegInvalidLimit, lim);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_sample rand_sample(int bad_pct);
        t_sample s;
        s.sample_valid = ($urandom_range(0, 99) >= bad_pct / 2);
        s.gyro_x  = pick16();
        s.gyro_y  = pick16();
        s.gyro_z  = pick16();
        s.accel_x = pick16();
        s.accel_y = pick16();
        s.accel_z = pick16();
        if ($urandom_range(0, 19) == 0) begin
            s.accel_x = 16'h0;
            s.accel_y = 16'h0;
            s.accel_z = 16'h0;
        end
        s.time_step = ($urandom_range(0, 99) < bad_pct / 2) ? 16'h0 : pick16();
        if (s.time_step == 16'h0 && $urandom_range(0, 1) == 0) s.time_step = 16'($urandom);
        return s;
    endfunction

    function automatic t_sample make_sample(logic v, logic [15:0] g, logic [15:0] a,
                                            logic [15:0] dt);
        t_sample s;
        s.sample_valid = v;
        s.gyro_x = g;
        s.gyro_y = g;
        s.gyro_z = g;
        s.accel_x = a;
        s.accel_y = a;
        s.accel_z = a;
        s.time_step = dt;
        return s;
    endfunction

    task automatic run_random(int n, int bad_pct);
        repeat (n) send_sample(rand_sample(bad_pct));
    endtask

    task automatic test_directed_extremes();
        t_sample s;
        send_sample(make_sample(1'b1, 16'h7fff, 16'h7fff, 16'hffff));
        send_sample(make_sample(1'b1, 16'h8000, 16'h8000, 16'hffff));
        send_sample(make_sample(1'b1, 16'h0000, 16'h0000, 16'h0001));
        send_sample(make_sample(1'b1, 16'h1000, 16'h0000, 16'h0100));
        s = make_sample(1'b1, 16'h0000, 16'h0000, 16'h0041);
        s.accel_z = 16'h8000;
        send_sample(s);
        s.accel_z = 16'h0100;
        s.accel_y = 16'hff00;
        send_sample(s);
        s.accel_z = 16'h0000;
        s.accel_x = 16'h0100;
        send_sample(s);
        s.accel_y = 16'h0000;
        s.accel_x = 16'h0000;
        s.accel_z = 16'h7fff;
        send_sample(s);
        send_sample(make_sample(1'b0, 16'h7fff, 16'h0100, 16'h1000));
        send_sample(make_sample(1'b1, 16'h7fff, 16'h0100, 16'h0000));
        send_sample(make_sample(1'b1, 16'h8000, 16'hff00, 16'h0040));
        wait_drained();
    endtask

    task automatic test_invalid_counter();
        set_filter(32'd40000, 32'd1, 32'd3);
        repeat (5) send_sample(make_sample(1'b0, 16'h0010, 16'h0100, 16'h0040));
        send_sample(make_sample(1'b1, 16'h0010, 16'h0100, 16'h0040));
        repeat (2) send_sample(make_sample(1'b1, 16'h0010, 16'h0100, 16'h0000));
        wait_drained();
        set_filter(32'd40000, 32'd1, 32'd0);
        repeat (2) send_sample(make_sample(1'b0, 16'h0010, 16'h0100, 16'h0040));
        send_sample(make_sample(1'b1, 16'h0010, 16'h0100, 16'h0040));
        wait_drained();
    endtask

    task automatic test_decimation();
        set_filter(32'd65000, 32'd0, 32'd10);
        run_random(4, 0);
        wait_drained();
        set_filter(32'd65000, 32'd3, 32'd10);
        run_random(12, 20);
        wait_drained();
    endtask

    task automatic test_random_settings();
        set_filter(32'd0, 32'd1, 32'd1);
        run_random(200, 30);
        wait_drained();
        set_filter(32'd65535, 32'd1, 32'd255);
        run_random(200, 10);
        wait_drained();
        set_filter(32'hffff0000 | 32'($urandom), 32'hffffff00 | 32'd2, 32'd5);
        run_random(200, 15);
        wait_drained();
        set_filter(32'd65535, 32'd255, 32'd255);
        run_random(300, 5);
        wait_drained();
        set_filter(32'd64225, 32'd1, 32'd10);
        run_random(300, 10);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        @(posedge i_clk);
        sink_hold <= 400;
        run_random(20, 10);
        wait_drained();
    endtask

    task automatic test_no_idle();
        set_filter(32'($urandom_range(0, 65535)), 32'($urandom_range(1, 4)),
                   32'($urandom_range(1, 255)));
        no_idle = 1'b1;
        run_random(300, 15);
        wait_drained();
    endtask

    initial begin
        weight_q  = BlendWeightRst;
        decim_q   = DecimationRst;
        limit_q   = InvalidLimitRst;
        bad_count = 0;
        ok_q      = 1'b1;
        decim_cnt = 0;
        roll_q    = 0;
        pitch_q   = 0;
        yaw_q     = 0;
        pi_fix    = longint'((PiQ62 + (64'd1 << 33)) >> 34);
        errors    = 0;
        cycles    = 0;
        no_idle   = 1'b0;
        sink_hold = 0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (DrainCycles) @(posedge i_clk);

        test_directed_extremes();
        test_invalid_counter();
        test_decimation();
        test_random_settings();
        test_output_backpressure();
        test_no_idle();

        wait_drained();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
